/* design/quad_procedural_pattern_assert.svh */
// ============================================================================
// Assertion macros for the quad procedural pattern generator
// Short forms for clocked assertions with reset disable.
// ============================================================================
`ifndef QUAD_PROCEDURAL_PATTERN_ASSERT_SVH
`define QUAD_PROCEDURAL_PATTERN_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QPP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quad_procedural_pattern: assertion failed");

// Next-cycle implication, checked out of reset.
`define QPP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quad_procedural_pattern: assertion failed");

`endif

/* design/qpp_pkg.sv */
// ============================================================================
// qpp_pkg
// Widths, constants and tables of the quad procedural pattern generator.
// ============================================================================
package qpp_pkg;

    localparam int COORD_BITS = 16;
    localparam int COLOR_BITS = 12;

    localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * COLOR_BITS + 7) / 8) * 8;

    localparam int CORDIC_STEPS = 14;

    typedef logic signed [18:0] cval_t;
    typedef logic signed [15:0] zval_t;
    typedef logic signed [19:0] val_t;

    // Quadrant of the image, from the top bits of v and u.
    typedef enum logic [1:0] {
        CELL_CHECKER = 2'd0,
        CELL_RINGS   = 2'd1,
        CELL_WAVES   = 2'd2,
        CELL_RADIAL  = 2'd3
    } cell_t;

    // Arctangent of 2^-i in turns scaled by 2^16.
    function automatic zval_t atan_turns(input int i);
        zval_t r;
        case (i)
            0:       r = 16'sd8192;
            1:       r = 16'sd4836;
            2:       r = 16'sd2555;
            3:       r = 16'sd1297;
            4:       r = 16'sd651;
            5:       r = 16'sd326;
            6:       r = 16'sd163;
            7:       r = 16'sd81;
            8:       r = 16'sd41;
            9:       r = 16'sd20;
            10:      r = 16'sd10;
            11:      r = 16'sd5;
            12:      r = 16'sd3;
            13:      r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

endpackage

/* design/quad_procedural_pattern.sv */
// ============================================================================
// quad_procedural_pattern
// Four-quadrant procedural test pattern: one coordinate in, one RGB color out.
// ============================================================================
//  channel   direction  fields (low bit first)
//  s_axis    in         tdata: coord_u[15:0], coord_v[31:16]
//  m_axis    out        tdata: red[11:0], green[23:12], blue[35:24], zero pad
//
//  One request per clock when the output side keeps up; 23 register stages, most
//  of them in the 16-step square root (8 stages, 2 bits each) and the 14-step
//  CORDIC (7 stages, 2 steps each), in series.
//  A stall at m_axis freezes the whole pipeline, so nothing is lost or repeated.
//  Reset clears only the valid bits; the data registers are not reset.
// ============================================================================
`include "quad_procedural_pattern_assert.svh"

module quad_procedural_pattern
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // coord_u, coord_v
    input  logic [qpp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // red, green, blue, zero pad
    output logic [qpp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import qpp_pkg::*;

    localparam int NSTG    = 23;
    localparam int SQ_STG  = 8;
    localparam int CO_STG  = 7;
    localparam int LANES   = 3;
    localparam int ST_PH   = 11;
    localparam int ST_M2   = 21;

    typedef struct packed {
        cell_t       quad;
        logic [15:0] lu;
        logic [15:0] lv;
    } front_t;

    typedef struct packed {
        cell_t       quad;
        logic        par;
        logic [16:0] d2;
    } side_t;

    logic [NSTG-1:0] vld_reg;
    logic            ce;

    assign ce            = !vld_reg[NSTG-1] || m_axis_tready;
    assign s_axis_tready = ce;
    assign m_axis_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], s_axis_tvalid};
        end
    end

    // ---------------- input stage: quadrant and local coordinates ----------
    logic [COORD_BITS-1:0] u_raw, v_raw, lu_l, lv_l;
    logic [23:0]           lu_w, lv_w;
    front_t                in_next, in_reg;

    always_comb
    begin
        u_raw        = s_axis_tdata[COORD_BITS-1:0];
        v_raw        = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        lu_l         = u_raw << 1;
        lv_l         = v_raw << 1;
        lu_w         = 24'(lu_l) << (24 - COORD_BITS);
        lv_w         = 24'(lv_l) << (24 - COORD_BITS);
        in_next.quad = cell_t'({v_raw[COORD_BITS-1], u_raw[COORD_BITS-1]});
        in_next.lu   = lu_w[23:8];
        in_next.lv   = lv_w[23:8];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            in_reg <= in_next;
        end
    end

    // ---------------- squares of the distance from the center -------------
    logic signed [16:0] dx, dy;
    logic signed [33:0] sqx_full, sqy_full;
    logic [31:0]        sqx_reg, sqy_reg, sum_reg;
    front_t             sq_fr_reg, sum_fr_reg;

    always_comb
    begin
        dx       = $signed({1'b0, in_reg.lu}) - 17'sd32768;
        dy       = $signed({1'b0, in_reg.lv}) - 17'sd32768;
        sqx_full = dx * dx;
        sqy_full = dy * dy;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sqx_reg    <= 32'(sqx_full);
            sqy_reg    <= 32'(sqy_full);
            sq_fr_reg  <= in_reg;
            sum_reg    <= sqx_reg + sqy_reg;
            sum_fr_reg <= sq_fr_reg;
        end
    end

    // ---------------- square root, two result bits per stage --------------
    logic [31:0] sn_reg [SQ_STG];
    logic [31:0] sr_reg [SQ_STG];
    front_t      sf_reg [SQ_STG];
    logic [31:0] sn_next [SQ_STG];
    logic [31:0] sr_next [SQ_STG];

    always_comb
    begin
        logic [31:0] n, r, b;
        for (int k = 0; k < SQ_STG; k++)
        begin
            n = (k == 0) ? sum_reg : sn_reg[(k == 0) ? 0 : k - 1];
            r = (k == 0) ? 32'd0   : sr_reg[(k == 0) ? 0 : k - 1];
            for (int j = 0; j < 2; j++)
            begin
                b = 32'd1 << (30 - 4 * k - 2 * j);
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
            end
            sn_next[k] = n;
            sr_next[k] = r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < SQ_STG; k++)
            begin
                sn_reg[k] <= sn_next[k];
                sr_reg[k] <= sr_next[k];
                sf_reg[k] <= (k == 0) ? sum_fr_reg : sf_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // ---------------- phases in turns -------------------------------------
    logic [15:0] rad_dist;
    logic [16:0] luv;
    logic [35:0] pd, pu, pv, puv;
    logic [16:0] d2_next;
    logic [15:0] ph_reg [LANES];
    side_t       ph_side_reg;
    front_t      sq_last;

    always_comb
    begin
        sq_last  = sf_reg[SQ_STG-1];
        rad_dist = sr_reg[SQ_STG-1][15:0];
        luv      = 17'(sq_last.lu) + 17'(sq_last.lv);
        pd       = 36'(rad_dist) * 36'd417215;
        pu       = 36'(sq_last.lu) * 36'd260759;
        pv       = 36'(sq_last.lv) * 36'd187747;
        puv      = 36'(luv) * 36'd125165;
        d2_next  = (rad_dist > 16'd32768) ? 17'd65536 : {rad_dist, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ph_reg[0]        <= (sq_last.quad == CELL_RINGS) ? pd[31:16] : pu[31:16];
            ph_reg[1]        <= pv[31:16];
            ph_reg[2]        <= puv[31:16];
            ph_side_reg.quad <= sq_last.quad;
            ph_side_reg.par  <= sq_last.lu[13] ^ sq_last.lv[13];
            ph_side_reg.d2   <= d2_next;
        end
    end

    // ---------------- CORDIC, two rotations per stage, three lanes --------
    cval_t       cx_reg [LANES][CO_STG];
    cval_t       cy_reg [LANES][CO_STG];
    zval_t       cz_reg [LANES][CO_STG];
    logic [1:0]  cq_reg [LANES][CO_STG];
    side_t       cs_reg [CO_STG];
    cval_t       cx_next [LANES][CO_STG];
    cval_t       cy_next [LANES][CO_STG];
    zval_t       cz_next [LANES][CO_STG];

    always_comb
    begin
        cval_t x, y, xs, ys;
        zval_t z;
        int    i;
        for (int l = 0; l < LANES; l++)
        begin
            for (int k = 0; k < CO_STG; k++)
            begin
                if (k == 0)
                begin
                    x = 19'sd39797;
                    y = 19'sd0;
                    z = $signed({2'b00, ph_reg[l][13:0]});
                end
                else
                begin
                    x = cx_reg[l][(k == 0) ? 0 : k - 1];
                    y = cy_reg[l][(k == 0) ? 0 : k - 1];
                    z = cz_reg[l][(k == 0) ? 0 : k - 1];
                end
                for (int j = 0; j < 2; j++)
                begin
                    i  = 2 * k + j;
                    xs = x >>> i;
                    ys = y >>> i;
                    if (z >= 0)
                    begin
                        x = x - ys;
                        y = y + xs;
                        z = z - atan_turns(i);
                    end
                    else
                    begin
                        x = x + ys;
                        y = y - xs;
                        z = z + atan_turns(i);
                    end
                end
                cx_next[l][k] = x;
                cy_next[l][k] = y;
                cz_next[l][k] = z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                for (int k = 0; k < CO_STG; k++)
                begin
                    cx_reg[l][k] <= cx_next[l][k];
                    cy_reg[l][k] <= cy_next[l][k];
                    cz_reg[l][k] <= cz_next[l][k];
                    cq_reg[l][k] <= (k == 0) ? ph_reg[l][15:14]
                                             : cq_reg[l][(k == 0) ? 0 : k - 1];
                end
            end
            for (int k = 0; k < CO_STG; k++)
            begin
                cs_reg[k] <= (k == 0) ? ph_side_reg : cs_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // ---------------- quadrant mapping to cosine and sine -----------------
    cval_t cos_m [LANES];
    cval_t sin_m [LANES];
    cval_t c0_reg, s0_reg, c1_reg, s2_reg;
    side_t map_side_reg;

    always_comb
    begin
        cval_t x, y;
        for (int l = 0; l < LANES; l++)
        begin
            x = cx_reg[l][CO_STG-1];
            y = cy_reg[l][CO_STG-1];
            case (cq_reg[l][CO_STG-1])
                2'd0:
                begin
                    cos_m[l] = x;
                    sin_m[l] = y;
                end
                2'd1:
                begin
                    cos_m[l] = -y;
                    sin_m[l] = x;
                end
                2'd2:
                begin
                    cos_m[l] = -x;
                    sin_m[l] = -y;
                end
                default:
                begin
                    cos_m[l] = y;
                    sin_m[l] = -x;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c0_reg       <= cos_m[0];
            s0_reg       <= sin_m[0];
            c1_reg       <= cos_m[1];
            s2_reg       <= sin_m[2];
            map_side_reg <= cs_reg[CO_STG-1];
        end
    end

    // ---------------- first product stage ---------------------------------
    logic signed [37:0] prod_a;
    logic [33:0]        prod_d;
    val_t               t1_reg, a_reg, s3_reg;
    logic [16:0]        p3_reg;
    side_t              m1_side_reg;

    always_comb
    begin
        prod_a = s0_reg * c1_reg;
        prod_d = 34'(map_side_reg.d2) * 34'd19661;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t1_reg      <= val_t'(20'sd32768 + 20'(c0_reg >>> 1));
            a_reg       <= val_t'(prod_a >>> 16);
            s3_reg      <= val_t'(s2_reg);
            p3_reg      <= prod_d[32:16];
            m1_side_reg <= map_side_reg;
        end
    end

    // ---------------- second product stage and color select --------------
    logic signed [35:0] prod_t1, prod_a2;
    val_t               t2, sum_as;
    val_t               r_next, g_next, b_next;
    val_t               red_reg, green_reg, blue_reg;
    cell_t              m2_cell_reg;

    always_comb
    begin
        prod_t1 = 36'(t1_reg) * 36'sd19661;
        prod_a2 = 36'(a_reg) * 36'sd19661;
        sum_as  = a_reg + s3_reg;
        t2      = 20'sd32768 + (sum_as >>> 2);
        case (m1_side_reg.quad)
            CELL_CHECKER:
            begin
                if (m1_side_reg.par)
                begin
                    r_next = 20'sd58982;
                    g_next = 20'sd58982;
                    b_next = 20'sd58982;
                end
                else
                begin
                    r_next = 20'sd6554;
                    g_next = 20'sd6554;
                    b_next = 20'sd9830;
                end
            end
            CELL_RINGS:
            begin
                r_next = t1_reg;
                g_next = 20'sd22938 + val_t'(prod_t1 >>> 16);
                b_next = 20'sd65536 - t1_reg;
            end
            CELL_WAVES:
            begin
                r_next = t2;
                g_next = 20'sd65536 - t2;
                b_next = 20'sd22938 + val_t'(prod_a2 >>> 16);
            end
            default:
            begin
                r_next = 20'sd65536 - $signed(20'(m1_side_reg.d2));
                g_next = 20'sd13107 + $signed(20'(p3_reg));
                b_next = $signed(20'(m1_side_reg.d2));
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            red_reg     <= r_next;
            green_reg   <= g_next;
            blue_reg    <= b_next;
            m2_cell_reg <= m1_side_reg.quad;
        end
    end

    // ---------------- output register -------------------------------------
    function automatic logic [COLOR_BITS-1:0] to_color(input val_t x);
        logic [39:0] c;
        if (x < 0)
        begin
            return '0;
        end
        c = ((40'(x) << COLOR_BITS) + 40'd32768) >> 16;
        if (c > 40'((1 << COLOR_BITS) - 1))
        begin
            return '1;
        end
        return c[COLOR_BITS-1:0];
    endfunction

    logic [OUT_TDATA_W-1:0] out_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_reg <= OUT_TDATA_W'({to_color(blue_reg), to_color(green_reg),
                                     to_color(red_reg)});
        end
    end

    assign m_axis_tdata = out_reg;

    // ---------------- assertions ------------------------------------------
    `QPP_ASSERT_NEXT(a_stall_freezes, !ce, $stable(vld_reg))
    `QPP_ASSERT_IMPL(a_checker_gray, vld_reg[ST_M2] && m2_cell_reg == CELL_CHECKER,
                     red_reg == green_reg)
    `QPP_ASSERT_IMPL(a_radial_clamped, vld_reg[ST_PH] && ph_side_reg.quad == CELL_RADIAL,
                     ph_side_reg.d2 <= 17'd65536)

endmodule

/* sim/qpp_checker.sv */
// ----------------------------------------------------------------------------
// Pattern color checker
// Watches both stream channels, predicts the color of each accepted coordinate
// and compares every returned color with the oldest prediction.
// ----------------------------------------------------------------------------
module qpp_checker
    import qpp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COLOR_BITS-1:0] blue;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] red;
    } rgb_t;

    localparam int PH_K40 = 417215;
    localparam int PH_K25 = 260759;
    localparam int PH_K18 = 187747;
    localparam int PH_K12 = 125165;

    rgb_t color_fifo[$];

    // Arithmetic shift right rounding toward minus infinity.
    function automatic longint shr_floor(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return shr_floor(a * b, 16);
    endfunction

    function automatic void cordic_sincos(input logic [15:0] ph, output longint c,
                                          output longint s);
        longint x, y, z, xs, ys;
        x = 39797;
        y = 0;
        z = ph[13:0];
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_turns(i);
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_turns(i);
            end
        end
        case (ph[15:14])
            2'd0:    begin c = x;  s = y;  end
            2'd1:    begin c = -y; s = x;  end
            2'd2:    begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endfunction

    function automatic logic [15:0] turn_phase(longint q, longint k);
        longint p;
        p = (q * k) >>> 16;
        return p[15:0];
    endfunction

    function automatic longint dist_q16(longint lu, longint lv);
        longint dx, dy, n, r, b;
        dx = lu - 32768;
        dy = lv - 32768;
        n = dx * dx + dy * dy;
        r = 0;
        b = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [COLOR_BITS-1:0] to_level(longint x);
        longint c;
        if (x < 0)
            return '0;
        c = ((x << COLOR_BITS) + 32768) >> 16;
        if (c > (1 << COLOR_BITS) - 1)
            c = (1 << COLOR_BITS) - 1;
        return c[COLOR_BITS-1:0];
    endfunction

    function automatic rgb_t pattern_color(logic [15:0] u, logic [15:0] v);
        cell_t  quad;
        longint lu, lv, r, g, b, c, s, c2, s2, c3, s3, t, a, d;
        rgb_t   res;
        quad = cell_t'({v[15], u[15]});
        lu = {u[14:0], 1'b0};
        lv = {v[14:0], 1'b0};
        case (quad)
            CELL_CHECKER:
            begin
                if (lu[13] ^ lv[13])
                begin
                    r = 58982; g = 58982; b = 58982;
                end
                else
                begin
                    r = 6554; g = 6554; b = 9830;
                end
            end
            CELL_RINGS:
            begin
                cordic_sincos(turn_phase(dist_q16(lu, lv), PH_K40), c, s);
                t = 32768 + shr_floor(c, 1);
                r = t;
                g = 22938 + qmul(19661, t);
                b = 65536 - t;
            end
            CELL_WAVES:
            begin
                cordic_sincos(turn_phase(lu, PH_K25), c, s);
                cordic_sincos(turn_phase(lv, PH_K18), c2, s2);
                cordic_sincos(turn_phase(lu + lv, PH_K12), c3, s3);
                a = qmul(s, c2);
                t = 32768 + shr_floor(a + s3, 2);
                r = t;
                g = 65536 - t;
                b = 22938 + qmul(19661, a);
            end
            default:
            begin
                d = dist_q16(lu, lv) * 2;
                if (d > 65536)
                    d = 65536;
                r = 65536 - d;
                g = 13107 + qmul(19661, d);
                b = d;
            end
        endcase
        res.red = to_level(r);
        res.green = to_level(g);
        res.blue = to_level(b);
        return res;
    endfunction

    assign pending = color_fifo.size();

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want, got;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                color_fifo.push_back(pattern_color(s_axis_tdata[15:0],
                                                   s_axis_tdata[31:16]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[3*COLOR_BITS-1:0];
                if (color_fifo.size() == 0)
                begin
                    $display("%0t: unexpected color %h, expected none", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = color_fifo.pop_front();
                    if (want !== got)
                    begin
                        $display("%0t: expected r=%0d g=%0d b=%0d, actual r=%0d g=%0d b=%0d",
                                 $time, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* sim/tb_quad_procedural_pattern.sv */
// ----------------------------------------------------------------------------
// Quad procedural pattern testbench
// Drives corner and random coordinates with random gaps and output stalls,
// including a long output hold-off; the checker predicts every color.
// ----------------------------------------------------------------------------
module tb_quad_procedural_pattern;
    import qpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 23;
    localparam int CYCLE_LIMIT = 200000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    int                      fail_count;
    int                      pending;
    int                      cycles = 0;
    logic                    hold_off = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quad_procedural_pattern i_dut (.*);

    qpp_checker i_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quad_procedural_pattern test failed");
            $finish;
        end
    end

    // Output side: random stall per color, plus a long hold-off on request.
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (hold_off)
                n = 150;
            m_axis_tready <= 1'b0;
            repeat (n) @(posedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_coord(logic [15:0] u, logic [15:0] v, bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 7) : 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v, u};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    initial
    begin
        logic [15:0] u, v;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners of every quadrant, three quadrant centers, and checker cell edges.
        send_coord(16'h0000, 16'h0000, 1);
        send_coord(16'hFFFF, 16'hFFFF, 1);
        send_coord(16'h7FFF, 16'h0000, 1);
        send_coord(16'h0000, 16'h7FFF, 1);
        send_coord(16'h8000, 16'h0000, 1);
        send_coord(16'h0000, 16'h8000, 1);
        send_coord(16'h8000, 16'h8000, 1);
        send_coord(16'hC000, 16'hC000, 1);
        send_coord(16'hC000, 16'h4000, 1);
        send_coord(16'h4000, 16'hC000, 1);
        send_coord(16'h1000, 16'h0000, 1);
        send_coord(16'h0FFF, 16'h1000, 1);
        send_coord(16'h1000, 16'h1000, 1);
        send_coord(16'h8000, 16'hFFFF, 1);
        send_coord(16'hFFFF, 16'h8000, 1);
        send_coord(16'hFFFF, 16'h0000, 1);
        send_coord(16'h0000, 16'hFFFF, 1);
        send_coord(16'hAAAA, 16'h5555, 1);
        send_coord(16'h5555, 16'hAAAA, 1);

        // Sender pauses until every color has come back.
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);

        // Output holds off for a long stretch while requests keep coming.
        hold_off = 1'b1;
        for (int i = 0; i < 60; i++)
            send_coord(16'($urandom), 16'($urandom), 0);
        hold_off = 1'b0;

        for (int i = 0; i < 1000; i++)
        begin
            u = 16'($urandom);
            v = 16'($urandom);
            send_coord(u, v, (i / 100) % 2 == 0);
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("quad_procedural_pattern test passed");
        else
            $display("quad_procedural_pattern test failed");
        $finish;
    end
endmodule
